### hdl/svp_pkg.sv
package svp_pkg;

    // Coordinate width and sine table geometry
    localparam int CoordWidth = 16;
    localparam int SineDepth  = 1024;
    localparam int SineAw     = $clog2(SineDepth);

    // Pipeline geometry
    localparam int DivStages  = 32;
    localparam int PostStages = 13;
    localparam int PipeDepth  = DivStages + PostStages;
    localparam int FifoDepth  = 4;
    localparam int FifoAw     = $clog2(FifoDepth);

    // Arithmetic constants
    localparam logic [15:0] Edge0    = 16'd9830;
    localparam logic [15:0] EdgeSpan = 16'd55706;
    localparam logic [15:0] BandLo   = 16'd9830;
    localparam logic [15:0] BandSpan = 16'd22938;
    localparam logic [63:0] RecipWide = (64'd1 << 47) / 64'd55706;
    localparam logic [31:0] RecipT    = RecipWide[31:0];
    localparam logic [11:0] BaseColor [3] = '{12'd1638, 12'd2294, 12'd3604};

    // Register reset values
    localparam logic [31:0] ResolutionRst = 32'd65537;
    localparam logic [11:0] StripeRst     = 12'd7;
    localparam logic [47:0] TintRst       = 48'h799A4666199A;
    localparam logic [63:0] VignetteRst   = 64'h028F051F0CCD6CCD;
    localparam logic [15:0] ExposureRst   = 16'd4096;

    typedef enum logic [2:0] {
        RegResolution = 3'd0,
        RegStripe     = 3'd1,
        RegInvert     = 3'd2,
        RegOffsetX    = 3'd3,
        RegOffsetY    = 3'd4,
        RegTint       = 3'd5,
        RegVignette   = 3'd6,
        RegExposure   = 3'd7
    } svp_reg_t;

    typedef struct packed {
        logic [31:0] resolution;
        logic [11:0] stripe_freq;
        logic        invert;
        logic [15:0] offset_x;
        logic [15:0] offset_y;
        logic [47:0] tint;
        logic [63:0] vignette;
        logic [15:0] exposure;
    } svp_cfg_t;

    // Item between front and back: divider numerators for u and v
    typedef struct packed {
        logic [31:0] num_u;
        logic [31:0] num_v;
    } svp_item_t;

    typedef logic [15:0] sine_rom_t [SineDepth];

    // Quarter-wave sine in Q1.15 by an integer Taylor series
    function automatic logic [15:0] sine_entry(input int unsigned i);
        logic [63:0] one;
        logic [63:0] t;
        logic [63:0] t2;
        logic [63:0] h;
        logic [63:0] v;
        one = 64'd1 << 30;
        t   = (64'd1686629713 * 64'(i)) / 64'(SineDepth);
        t2  = (t * t) >> 30;
        h   = one - t2 / 64'd110;
        h   = one - ((t2 * h) >> 30) / 64'd72;
        h   = one - ((t2 * h) >> 30) / 64'd42;
        h   = one - ((t2 * h) >> 30) / 64'd20;
        h   = one - ((t2 * h) >> 30) / 64'd6;
        v   = (((t * h) >> 30) + 64'd16384) >> 15;
        return (v > 64'd32768) ? 16'd32768 : v[15:0];
    endfunction

    function automatic sine_rom_t sine_rom_build();
        sine_rom_t tab;
        for (int i = 0; i < SineDepth; i++) begin
            tab[i] = sine_entry(i);
        end
        return tab;
    endfunction

    localparam sine_rom_t SineRom = sine_rom_build();

endpackage

### hdl/svp_ram.sv
module svp_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(Depth)-1:0] wr_addr,
    input  logic [Width-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(Depth)-1:0] rd_addr,
    output logic [Width-1:0]         rd_data
);

    logic [Width-1:0] mem [Depth];
    logic [Width-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/svp_div.sv
module svp_div import svp_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [31:0] num,
    input  logic [15:0] den,
    output logic [31:0] quo
);

    // One quotient bit per stage, restoring
    logic [15:0] rem_reg  [DivStages];
    logic [31:0] num_reg  [DivStages];
    logic [31:0] quo_reg  [DivStages];
    logic [15:0] den_reg  [DivStages];
    logic [15:0] rem_next [DivStages];
    logic [31:0] num_next [DivStages];
    logic [31:0] quo_next [DivStages];
    logic [15:0] den_next [DivStages];

    for (genvar j = 0; j < DivStages; j++) begin : g_stage
        logic [15:0] rem_in;
        logic [31:0] num_in;
        logic [31:0] quo_in;
        logic [15:0] den_in;
        logic [16:0] trial;
        logic        ge;

        if (j == 0) begin : g_first
            assign rem_in = 16'd0;
            assign num_in = num;
            assign quo_in = 32'd0;
            assign den_in = den;
        end else begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign num_in = num_reg[j-1];
            assign quo_in = quo_reg[j-1];
            assign den_in = den_reg[j-1];
        end

        always_comb begin
            trial       = {rem_in, num_in[31]};
            ge          = (trial >= {1'b0, den_in});
            rem_next[j] = ge ? 16'(trial - {1'b0, den_in}) : trial[15:0];
            num_next[j] = {num_in[30:0], 1'b0};
            quo_next[j] = {quo_in[30:0], ge};
            den_next[j] = den_in;
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= rem_next[j];
                num_reg[j] <= num_next[j];
                quo_reg[j] <= quo_next[j];
                den_reg[j] <= den_next[j];
            end
        end
    end

    assign quo = quo_reg[DivStages-1];

endmodule

### hdl/svp_fifo.sv
module svp_fifo import svp_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  svp_item_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output svp_item_t pop_data
);

    svp_item_t         buf_reg [FifoDepth];
    logic [FifoAw-1:0] wr_ptr_reg;
    logic [FifoAw-1:0] rd_ptr_reg;
    logic [FifoAw:0]   count_reg;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (count_reg != (FifoAw+1)'(FifoDepth));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = buf_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            buf_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### hdl/svp_front.sv
module svp_front import svp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        enable,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_pixel_x,
    input  logic [15:0] s_pixel_y,
    output logic        push_valid,
    input  logic        push_ready,
    output svp_item_t   push_data
);

    localparam logic [15:0] CoordMask = 16'((32'd1 << CoordWidth) - 1);

    svp_item_t   item_reg;
    logic        vld_reg;
    logic [15:0] px;
    logic [15:0] py;
    logic        take;

    assign s_ready    = enable && (!vld_reg || push_ready);
    assign take       = s_valid && s_ready;
    assign px         = s_pixel_x & CoordMask;
    assign py         = s_pixel_y & CoordMask;
    assign push_valid = vld_reg;
    assign push_data  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (take) begin
            vld_reg <= 1'b1;
        end else if (push_ready) begin
            vld_reg <= 1'b0;
        end
    end

    // (2p + 1) << 15
    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg.num_u <= {px, 1'b1, 15'd0};
            item_reg.num_v <= {py, 1'b1, 15'd0};
        end
    end

endmodule

### hdl/svp_back.sv
module svp_back import svp_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  svp_cfg_t   cfg,
    input  logic       pop_valid,
    output logic       pop_ready,
    input  svp_item_t  pop_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_red,
    output logic [7:0] m_green,
    output logic [7:0] m_blue,
    output logic       init_done
);

    localparam int IdxProdW = 14 + SineAw + 1;

    logic                 adv;
    logic [PipeDepth-1:0] vld_reg;
    logic                 m_valid_reg;
    logic [7:0]           out_reg [3];

    assign adv       = !m_valid_reg || m_ready;
    assign pop_ready = adv;
    assign m_valid   = m_valid_reg;
    assign m_red     = out_reg[0];
    assign m_green   = out_reg[1];
    assign m_blue    = out_reg[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[PipeDepth-2:0], pop_valid};
            m_valid_reg <= vld_reg[PipeDepth-1];
        end
    end

    // Configuration-derived values
    logic [15:0] den_w;
    logic [15:0] den_h;
    logic [11:0] cnt_abs;
    logic [11:0] cnt_n;
    logic [11:0] cnt_n2;
    logic [15:0] strength;
    logic [15:0] tc [3];
    logic [15:0] vc [3];

    always_comb begin
        den_w    = (cfg.resolution[31:16] == 16'd0) ? 16'd1 : cfg.resolution[31:16];
        den_h    = (cfg.resolution[15:0] == 16'd0) ? 16'd1 : cfg.resolution[15:0];
        cnt_abs  = cfg.stripe_freq[11] ? (~cfg.stripe_freq + 12'd1) : cfg.stripe_freq;
        cnt_n    = (cnt_abs == 12'd0) ? 12'd1 : cnt_abs;
        cnt_n2   = cnt_n + 12'd2;
        strength = (cfg.vignette[15:0] > 16'h8000) ? 16'h8000 : cfg.vignette[15:0];
        tc[0]    = cfg.tint[47:32];
        tc[1]    = cfg.tint[31:16];
        tc[2]    = cfg.tint[15:0];
        vc[0]    = cfg.vignette[63:48];
        vc[1]    = cfg.vignette[47:32];
        vc[2]    = cfg.vignette[31:16];
    end

    // UV by pipelined division
    logic [31:0] u_q;
    logic [31:0] v_q;

    svp_div u_div_u (
        .aclk (aclk),
        .en   (adv),
        .num  (pop_data.num_u),
        .den  (den_w),
        .quo  (u_q)
    );

    svp_div u_div_v (
        .aclk (aclk),
        .en   (adv),
        .num  (pop_data.num_v),
        .den  (den_h),
        .quo  (v_q)
    );

    // Sine table fill after reset
    logic [SineAw-1:0] init_addr_reg;
    logic              init_done_reg;

    assign init_done = init_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_addr_reg <= '0;
            init_done_reg <= 1'b0;
        end else if (!init_done_reg) begin
            init_addr_reg <= init_addr_reg + 1'b1;
            if (init_addr_reg == SineAw'(SineDepth - 1)) begin
                init_done_reg <= 1'b1;
            end
        end
    end

    function automatic logic [16:0] edge_dist(input logic [31:0] q);
        logic [16:0] tw;
        logic [16:0] dd;
        tw = {q[15:0], 1'b0};
        if (q[31:16] != 16'd0) begin
            dd = 17'h10000;
        end else if (tw >= 17'h10000) begin
            dd = tw - 17'h10000;
        end else begin
            dd = 17'h10000 - tw;
        end
        return dd;
    endfunction

    // {negative, quarter point, table address}
    function automatic logic [SineAw+1:0] quarter_map(input logic [15:0] ph);
        logic [14:0]         kq;
        logic [IdxProdW-1:0] prod;
        if (ph[14]) begin
            kq = 15'h4000 - {1'b0, ph[13:0]};
        end else begin
            kq = {1'b0, ph[13:0]};
        end
        prod = IdxProdW'(kq[13:0]) * IdxProdW'(SineDepth);
        return {ph[15], kq[14], prod[14 +: SineAw]};
    endfunction

    function automatic logic [15:0] wave(input logic neg, input logic full,
                                         input logic [15:0] tv);
        logic [16:0] mag;
        logic [16:0] sum;
        mag = full ? 17'h8000 : {1'b0, tv};
        sum = neg ? (17'h8000 - mag) : (17'h8000 + mag);
        return sum[16:1];
    endfunction

    // Stage registers after the dividers
    logic [15:0] su1_reg;
    logic [16:0] sv1_reg;
    logic [16:0] du1_reg;
    logic [16:0] dv1_reg;
    logic [15:0] phs2_reg;
    logic [15:0] phb2_reg;
    logic [15:0] x2_reg;
    logic        negs3_reg;
    logic        fulls3_reg;
    logic        negb3_reg;
    logic        fullb3_reg;
    logic [47:0] tprod3_reg;
    logic [15:0] x3_reg;
    logic [15:0] sw4_reg;
    logic [15:0] bw4_reg;
    logic [16:0] qe4_reg;
    logic [32:0] qd4_reg;
    logic [15:0] x4_reg;
    logic [16:0] t5_reg;
    logic [15:0] bf5_reg;
    logic [15:0] sw5_reg;
    logic [32:0] tt6_reg;
    logic [17:0] poly6_reg;
    logic [27:0] pa6_reg [3];
    logic [31:0] pb6_reg [3];
    logic [15:0] bf6_reg;
    logic [15:0] s7_reg;
    logic [15:0] c1_7_reg [3];
    logic [15:0] bf7_reg;
    logic [31:0] ks8_reg;
    logic [31:0] c2p8_reg [3];
    logic [15:0] k9_reg;
    logic [15:0] c2_9_reg [3];
    logic [31:0] pa10_reg [3];
    logic [31:0] pb10_reg [3];
    logic [15:0] c3_11_reg [3];
    logic [31:0] e12_reg [3];
    logic [15:0] f13_reg [3];

    // Combinational helpers per stage
    logic [16:0]       dmax;
    logic [27:0]       phs_prod;
    logic [28:0]       phb_prod;
    logic [SineAw+1:0] qmap_s;
    logic [SineAw+1:0] qmap_b;
    logic [15:0]       tab_s;
    logic [15:0]       tab_b;
    logic [31:0]       trem;
    logic [30:0]       bf_prod;
    logic [50:0]       s_prod;
    logic [32:0]       c1_sum [3];
    logic [32:0]       c3_sum [3];
    logic [19:0]       c4 [3];
    logic [23:0]       o_sum [3];

    always_comb begin
        dmax     = (du1_reg > dv1_reg) ? du1_reg : dv1_reg;
        phs_prod = 28'(su1_reg) * 28'(cnt_n);
        phb_prod = 29'(sv1_reg) * 29'(cnt_n2);
        qmap_s   = quarter_map(phs2_reg);
        qmap_b   = quarter_map(phb2_reg);
        trem     = {x4_reg, 16'd0} - qd4_reg[31:0];
        bf_prod  = 31'(bw4_reg) * 31'(BandSpan);
        s_prod   = 51'(tt6_reg) * 51'(poly6_reg);
        for (int ch = 0; ch < 3; ch++) begin
            c1_sum[ch] = 33'(pa6_reg[ch]) + 33'(pb6_reg[ch]);
            c3_sum[ch] = 33'(pa10_reg[ch]) + 33'(pb10_reg[ch]);
            c4[ch]     = e12_reg[ch][31:12];
            o_sum[ch]  = 24'(f13_reg[ch]) * 24'd255 + 24'd16384;
        end
    end

    svp_ram #(.Width(16), .Depth(SineDepth)) u_ram_stripe (
        .aclk    (aclk),
        .wr_en   (!init_done_reg),
        .wr_addr (init_addr_reg),
        .wr_data (SineRom[init_addr_reg]),
        .rd_en   (adv),
        .rd_addr (qmap_s[SineAw-1:0]),
        .rd_data (tab_s)
    );

    svp_ram #(.Width(16), .Depth(SineDepth)) u_ram_band (
        .aclk    (aclk),
        .wr_en   (!init_done_reg),
        .wr_addr (init_addr_reg),
        .wr_data (SineRom[init_addr_reg]),
        .rd_en   (adv),
        .rd_addr (qmap_b[SineAw-1:0]),
        .rd_data (tab_b)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            // offset UV, edge distances
            su1_reg <= u_q[15:0] + {cfg.offset_x[11:0], 4'd0};
            sv1_reg <= v_q[16:0] + {cfg.offset_y[12:0], 4'd0};
            du1_reg <= edge_dist(u_q);
            dv1_reg <= edge_dist(v_q);
            // phases, smoothstep input
            phs2_reg <= phs_prod[15:0];
            phb2_reg <= phb_prod[16:1] + 16'h4000;
            x2_reg   <= (dmax > {1'b0, Edge0}) ? 16'(dmax - {1'b0, Edge0}) : 16'd0;
            // table read, reciprocal product
            negs3_reg  <= qmap_s[SineAw+1];
            fulls3_reg <= qmap_s[SineAw];
            negb3_reg  <= qmap_b[SineAw+1];
            fullb3_reg <= qmap_b[SineAw];
            tprod3_reg <= 48'(x2_reg) * 48'(RecipT);
            x3_reg     <= x2_reg;
            // waves, quotient estimate
            sw4_reg <= wave(negs3_reg, fulls3_reg, tab_s);
            bw4_reg <= wave(negb3_reg, fullb3_reg, tab_b);
            qe4_reg <= tprod3_reg[47:31];
            qd4_reg <= 33'(tprod3_reg[47:31]) * 33'(EdgeSpan);
            x4_reg  <= x3_reg;
            // quotient correction, band factor
            t5_reg  <= (trem >= 32'(EdgeSpan)) ? (qe4_reg + 17'd1) : qe4_reg;
            bf5_reg <= BandLo + bf_prod[30:15];
            sw5_reg <= sw4_reg;
            // smoothstep square, stripe blend products
            tt6_reg   <= 33'(34'(t5_reg) * 34'(t5_reg));
            poly6_reg <= 18'd196608 - {t5_reg, 1'b0};
            bf6_reg   <= bf5_reg;
            // smoothstep value, stripe blend
            s7_reg  <= s_prod[48:33];
            bf7_reg <= bf6_reg;
            // vignette weight, band shade
            ks8_reg <= 32'(s7_reg) * 32'(strength);
            k9_reg  <= ks8_reg[30:15];
            for (int ch = 0; ch < 3; ch++) begin
                pa6_reg[ch]   <= 28'(BaseColor[ch]) * 28'(16'h8000 - sw5_reg);
                pb6_reg[ch]   <= 32'(tc[ch]) * 32'(sw5_reg);
                c1_7_reg[ch]  <= c1_sum[ch][30:15];
                c2p8_reg[ch]  <= 32'(c1_7_reg[ch]) * 32'(bf7_reg);
                c2_9_reg[ch]  <= c2p8_reg[ch][30:15];
                pa10_reg[ch]  <= 32'(c2_9_reg[ch]) * 32'(16'h8000 - k9_reg);
                pb10_reg[ch]  <= 32'(vc[ch]) * 32'(k9_reg);
                c3_11_reg[ch] <= c3_sum[ch][30:15];
                e12_reg[ch]   <= 32'(c3_11_reg[ch]) * 32'(cfg.exposure);
                if (cfg.invert) begin
                    f13_reg[ch] <= (c4[ch] >= 20'h8000) ? 16'd0 :
                                   16'(20'h8000 - c4[ch]);
                end else begin
                    f13_reg[ch] <= (c4[ch] > 20'h8000) ? 16'h8000 : c4[ch][15:0];
                end
                out_reg[ch] <= o_sum[ch][22:15];
            end
        end
    end

endmodule

### hdl/stripe_vignette_pattern_pixel.sv
// Channel  | Ports                                  | Handshake
// ---------+----------------------------------------+----------------------------
// input    | s_pixel_x, s_pixel_y                   | s_valid / s_ready
// result   | m_red, m_green, m_blue                 | m_valid / m_ready
// config   | cfg_index, cfg_wdata                   | cfg_wr_en, no wait
//
// One pixel per clock sustained while m_ready is high; a taken request passes
// the input register, the queue write, the 32-stage divider for u and v, 13
// arithmetic stages and the output register; the input register loads on the
// accepting edge itself. After reset the sine table is filled, one entry a
// cycle, all 1024 entries; s_ready stays low until the fill ends.
// A stall on m_ready holds the whole back pipeline; the front and its 4-entry
// queue keep taking requests until the queue fills.
module stripe_vignette_pattern_pixel import svp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_pixel_x,
    input  logic [15:0] s_pixel_y,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    svp_cfg_t  cfg_reg;
    logic      init_done;
    logic      front_valid;
    logic      front_ready;
    svp_item_t front_data;
    logic      back_valid;
    logic      back_ready;
    svp_item_t back_data;

    // Register file: take a write whenever the enable is high
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.resolution  <= ResolutionRst;
            cfg_reg.stripe_freq <= StripeRst;
            cfg_reg.invert      <= 1'b0;
            cfg_reg.offset_x    <= 16'd0;
            cfg_reg.offset_y    <= 16'd0;
            cfg_reg.tint        <= TintRst;
            cfg_reg.vignette    <= VignetteRst;
            cfg_reg.exposure    <= ExposureRst;
        end else if (cfg_wr_en) begin
            case (svp_reg_t'(cfg_index))
                RegResolution: begin
                    cfg_reg.resolution <= cfg_wdata[31:0];
                end
                RegStripe: begin
                    cfg_reg.stripe_freq <= cfg_wdata[11:0];
                end
                RegInvert: begin
                    cfg_reg.invert <= cfg_wdata[0];
                end
                RegOffsetX: begin
                    cfg_reg.offset_x <= cfg_wdata[15:0];
                end
                RegOffsetY: begin
                    cfg_reg.offset_y <= cfg_wdata[15:0];
                end
                RegTint: begin
                    cfg_reg.tint <= cfg_wdata[47:0];
                end
                RegVignette: begin
                    cfg_reg.vignette <= cfg_wdata;
                end
                RegExposure: begin
                    cfg_reg.exposure <= cfg_wdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Front: accept the request, mask the coordinates, form the numerators
    svp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .enable     (init_done),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_pixel_x  (s_pixel_x),
        .s_pixel_y  (s_pixel_y),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_data)
    );

    // Queue decouples the front from back-pipeline stalls
    svp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_data),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_data   (back_data)
    );

    // Back: divide, look up waves, blend, shade, vignette, expose, invert, saturate
    svp_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .pop_valid (back_valid),
        .pop_ready (back_ready),
        .pop_data  (back_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_red     (m_red),
        .m_green   (m_green),
        .m_blue    (m_blue),
        .init_done (init_done)
    );

endmodule
